// ----- hdl/etfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the escape-time fractal pixel engine.
// Used by etfp_mac, etfp_seq and escape_time_fractal_pixel; no dependencies.
package etfp_pkg;

  localparam int WORD_W    = 32;
  localparam int OPND_W    = 33;
  localparam int ACC_W     = 66;
  localparam int CFG_IDX_W = 3;
  localparam int LIMIT_W   = 20;
  localparam int EXPO_W    = 4;
  localparam int ALG_W     = 2;

  localparam logic [ALG_W-1:0] ALG_SQUARE = 2'd0;
  localparam logic [ALG_W-1:0] ALG_POWER  = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_ORIGIN_IMAG = 3'd1,
    REG_STEP_REAL   = 3'd2,
    REG_STEP_IMAG   = 3'd3,
    REG_MAX_ITER    = 3'd4,
    REG_ALGORITHM   = 3'd5,
    REG_EXPONENT    = 3'd6,
    REG_TEST_MODE   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_CR,
    DST_CI,
    DST_WR,
    DST_WI,
    DST_ESC
  } dst_t;

  typedef enum logic [1:0] {
    JOB_C,
    JOB_MUL,
    JOB_ESC
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPS,
    ST_DRAIN,
    ST_INIT,
    ST_ITER,
    ST_POW,
    ST_SUB,
    ST_TEST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] origin_real;
    logic signed [WORD_W-1:0] origin_imag;
    logic signed [WORD_W-1:0] step_real;
    logic signed [WORD_W-1:0] step_imag;
    logic [LIMIT_W-1:0]       max_iterations;
    logic [ALG_W-1:0]         algorithm;
    logic [EXPO_W-1:0]        exponent;
    logic                     test_mode;
  } cfg_t;

  // one multiply-accumulate request; a result is returned for every dst other than none
  typedef struct packed {
    logic                     valid;
    logic                     clr;
    logic                     neg;
    dst_t                     dst;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } mac_op_t;

  typedef struct packed {
    logic                    valid;
    logic                    pending;
    dst_t                    dst;
    logic signed [ACC_W-1:0] acc;
  } mac_res_t;

  localparam logic signed [ACC_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -66'sd2147483648;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/etfp_mac.sv -----
`timescale 1ns / 1ps
// Shared signed 33x33 multiplier with registered product and 66-bit accumulator.
// Depends on etfp_pkg.
module etfp_mac (
  input  logic              clk,
  input  logic              rst,
  input  etfp_pkg::mac_op_t op,
  output etfp_pkg::mac_res_t res
);

  logic signed [etfp_pkg::ACC_W-1:0] mul_w;
  logic signed [etfp_pkg::ACC_W-1:0] prod;
  logic signed [etfp_pkg::ACC_W-1:0] acc;
  logic                              s1_valid;
  logic                              s1_clr;
  logic                              s1_neg;
  etfp_pkg::dst_t                    s1_dst;
  logic                              done;
  etfp_pkg::dst_t                    done_dst;

  assign mul_w = op.a * op.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= op.valid;
      done     <= s1_valid & (s1_dst != etfp_pkg::DST_NONE);
    end
    prod   <= mul_w;
    s1_clr <= op.clr;
    s1_neg <= op.neg;
    s1_dst <= op.dst;
    if (s1_valid) begin
      acc      <= (s1_clr ? '0 : acc) + (s1_neg ? -prod : prod);
      done_dst <= s1_dst;
    end
  end

  always_comb begin
    res.valid   = done;
    res.pending = s1_valid | done;
    res.dst     = done_dst;
    res.acc     = acc;
  end

endmodule

// ----- hdl/etfp_seq.sv -----
`timescale 1ns / 1ps
// Per-pixel sequencer: forms c, runs the z^n - c iteration and the escape test
// by issuing words to the shared multiplier. Depends on etfp_pkg.
module etfp_seq #(
  parameter int COORD_BITS   = 16,
  parameter int FRAC_BITS    = 28,
  parameter int ITER_BITS    = 20,
  parameter int MAX_EXPONENT = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  etfp_pkg::cfg_t              cfg,
  input  logic                        start,
  input  logic [COORD_BITS-1:0]       pixel_x,
  input  logic [COORD_BITS-1:0]       pixel_y,
  output logic                        busy,
  output logic                        done,
  output logic [ITER_BITS-1:0]        count,
  output etfp_pkg::mac_op_t           op,
  input  etfp_pkg::mac_res_t          res
);

  localparam int EXP_W = $clog2(MAX_EXPONENT + 1);
  localparam logic signed [etfp_pkg::WORD_W-1:0] ONE = 32'(64'sd1 << FRAC_BITS);
  localparam logic signed [etfp_pkg::ACC_W-1:0] THRESH = 66'sd2 <<< (2 * FRAC_BITS);

  etfp_pkg::state_t state, state_next;
  etfp_pkg::job_t   job;
  logic [1:0]       cnt;
  logic [COORD_BITS-1:0] x, y;
  logic signed [etfp_pkg::WORD_W-1:0] cr, ci, wr, wi, zr, zi;
  logic [EXP_W-1:0] k;
  logic [EXP_W-1:0] n;
  logic [ITER_BITS-1:0] i_cnt;
  logic [ITER_BITS-1:0] lim;
  logic [ITER_BITS-1:0] i_inc;
  logic                 esc;
  logic [ITER_BITS-1:0] fin_count;
  logic [15:0]          tprod;
  logic                 alg_ok;
  logic                 op_last;

  assign lim    = cfg.max_iterations[ITER_BITS-1:0];
  assign i_inc  = ITER_BITS'(i_cnt + 1'b1);
  assign tprod  = pixel_x[7:0] * pixel_y[7:0];
  assign alg_ok = (cfg.algorithm == etfp_pkg::ALG_SQUARE) ||
                  (cfg.algorithm == etfp_pkg::ALG_POWER);

  always_comb begin
    if (cfg.algorithm == etfp_pkg::ALG_SQUARE) begin
      n = EXP_W'(2);
    end else if (32'(cfg.exponent) > MAX_EXPONENT) begin
      n = EXP_W'(MAX_EXPONENT);
    end else begin
      n = EXP_W'(cfg.exponent);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      etfp_pkg::ST_IDLE: begin
        if (start) begin
          if (!cfg.test_mode && alg_ok) begin
            state_next = etfp_pkg::ST_OPS;
          end else begin
            state_next = etfp_pkg::ST_FINISH;
          end
        end
      end
      etfp_pkg::ST_OPS: begin
        if (op_last) state_next = etfp_pkg::ST_DRAIN;
      end
      etfp_pkg::ST_DRAIN: begin
        if (!res.pending) begin
          unique case (job)
            etfp_pkg::JOB_C:   state_next = etfp_pkg::ST_INIT;
            etfp_pkg::JOB_MUL: state_next = etfp_pkg::ST_POW;
            default:           state_next = etfp_pkg::ST_TEST;
          endcase
        end
      end
      etfp_pkg::ST_INIT: begin
        state_next = (lim == '0) ? etfp_pkg::ST_FINISH : etfp_pkg::ST_ITER;
      end
      etfp_pkg::ST_ITER: state_next = etfp_pkg::ST_POW;
      etfp_pkg::ST_POW: begin
        state_next = (k < n) ? etfp_pkg::ST_OPS : etfp_pkg::ST_SUB;
      end
      etfp_pkg::ST_SUB: state_next = etfp_pkg::ST_OPS;
      etfp_pkg::ST_TEST: begin
        if (esc || i_inc == lim) begin
          state_next = etfp_pkg::ST_FINISH;
        end else begin
          state_next = etfp_pkg::ST_ITER;
        end
      end
      etfp_pkg::ST_FINISH: state_next = etfp_pkg::ST_IDLE;
      default: state_next = etfp_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier words
  always_comb begin
    busy  = (state != etfp_pkg::ST_IDLE);
    done  = (state == etfp_pkg::ST_FINISH);
    count = fin_count;
    op_last = (job == etfp_pkg::JOB_ESC) ? (cnt == 2'd1) : (cnt == 2'd3);
    op.valid = (state == etfp_pkg::ST_OPS);
    op.clr   = ~cnt[0];
    op.neg   = 1'b0;
    op.dst   = etfp_pkg::DST_NONE;
    op.a     = '0;
    op.b     = '0;
    unique case (job)
      etfp_pkg::JOB_C: begin
        unique case (cnt)
          2'd0: begin
            op.a = 33'(cfg.origin_real);
            op.b = 33'sd1;
          end
          2'd1: begin
            op.a   = $signed(33'(x));
            op.b   = 33'(cfg.step_real);
            op.dst = etfp_pkg::DST_CR;
          end
          2'd2: begin
            op.a = 33'(cfg.origin_imag);
            op.b = 33'sd1;
          end
          default: begin
            op.a   = $signed(33'(y));
            op.b   = 33'(cfg.step_imag);
            op.dst = etfp_pkg::DST_CI;
          end
        endcase
      end
      etfp_pkg::JOB_MUL: begin
        unique case (cnt)
          2'd0: begin
            op.a = 33'(wr);
            op.b = 33'(zr);
          end
          2'd1: begin
            op.a   = 33'(wi);
            op.b   = 33'(zi);
            op.neg = 1'b1;
            op.dst = etfp_pkg::DST_WR;
          end
          2'd2: begin
            op.a = 33'(wr);
            op.b = 33'(zi);
          end
          default: begin
            op.a   = 33'(wi);
            op.b   = 33'(zr);
            op.dst = etfp_pkg::DST_WI;
          end
        endcase
      end
      default: begin
        if (cnt[0]) begin
          op.a   = 33'(zi);
          op.b   = 33'(zi);
          op.dst = etfp_pkg::DST_ESC;
        end else begin
          op.a = 33'(zr);
          op.b = 33'(zr);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etfp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end

    if (res.valid) begin
      unique case (res.dst)
        etfp_pkg::DST_CR:  cr  <= etfp_pkg::sat32(res.acc);
        etfp_pkg::DST_CI:  ci  <= etfp_pkg::sat32(res.acc);
        etfp_pkg::DST_WR:  wr  <= etfp_pkg::sat32(res.acc >>> FRAC_BITS);
        etfp_pkg::DST_WI:  wi  <= etfp_pkg::sat32(res.acc >>> FRAC_BITS);
        etfp_pkg::DST_ESC: esc <= (res.acc >= THRESH);
        default: ;
      endcase
    end

    unique case (state)
      etfp_pkg::ST_IDLE: begin
        x         <= pixel_x;
        y         <= pixel_y;
        job       <= etfp_pkg::JOB_C;
        cnt       <= 2'd0;
        fin_count <= cfg.test_mode ? ITER_BITS'(tprod[7:0]) : '0;
      end
      etfp_pkg::ST_OPS: cnt <= cnt + 2'd1;
      etfp_pkg::ST_INIT: begin
        i_cnt     <= '0;
        zr        <= '0;
        zi        <= '0;
        fin_count <= '0;
      end
      etfp_pkg::ST_ITER: begin
        if (n == '0) begin
          wr <= ONE;
          wi <= '0;
          k  <= '0;
        end else begin
          wr <= zr;
          wi <= zi;
          k  <= EXP_W'(1);
        end
      end
      etfp_pkg::ST_POW: begin
        if (k < n) begin
          job <= etfp_pkg::JOB_MUL;
          cnt <= 2'd0;
          k   <= k + 1'b1;
        end
      end
      etfp_pkg::ST_SUB: begin
        zr  <= etfp_pkg::sat32(66'(wr) - 66'(cr));
        zi  <= etfp_pkg::sat32(66'(wi) - 66'(ci));
        job <= etfp_pkg::JOB_ESC;
        cnt <= 2'd0;
      end
      etfp_pkg::ST_TEST: begin
        if (esc) begin
          fin_count <= i_cnt;
        end else if (i_inc == lim) begin
          fin_count <= lim;
        end else begin
          i_cnt <= i_inc;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/escape_time_fractal_pixel.sv -----
`timescale 1ns / 1ps
// Escape-time fractal pixel engine: configuration registers, sequencer, shared multiplier.
// Each pixel runs m iterations, m the iterations run (count, plus one on escape), each raising z
// to the effective power n (2 in mode 0), where n may be 0, and testing for escape; one 33x33 multiplier
// serves every product. Test mode and unknown modes go from accept to done without iterating.
// One word at a time: next accept in the cycle after done; the receiver cannot stall.
// Synchronous active-high reset restores register defaults and idles the sequencer.
module escape_time_fractal_pixel #(
  parameter int COORD_BITS   = 16,
  parameter int FRAC_BITS    = 28,
  parameter int ITER_BITS    = 20,
  parameter int MAX_EXPONENT = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [etfp_pkg::WORD_W-1:0]        cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [COORD_BITS-1:0]              pixel_x,
  input  logic [COORD_BITS-1:0]              pixel_y,
  output logic                               done,
  output logic [etfp_pkg::LIMIT_W-1:0]       iteration_count
);

  etfp_pkg::cfg_t     cfg;
  etfp_pkg::mac_op_t  op;
  etfp_pkg::mac_res_t res;
  logic [ITER_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_real    <= '0;
      cfg.origin_imag    <= '0;
      cfg.step_real      <= '0;
      cfg.step_imag      <= '0;
      cfg.max_iterations <= 20'd256;
      cfg.algorithm      <= etfp_pkg::ALG_SQUARE;
      cfg.exponent       <= 4'd2;
      cfg.test_mode      <= 1'b0;
    end else if (cfg_write) begin
      unique case (etfp_pkg::reg_idx_t'(cfg_index))
        etfp_pkg::REG_ORIGIN_REAL: cfg.origin_real    <= cfg_data;
        etfp_pkg::REG_ORIGIN_IMAG: cfg.origin_imag    <= cfg_data;
        etfp_pkg::REG_STEP_REAL:   cfg.step_real      <= cfg_data;
        etfp_pkg::REG_STEP_IMAG:   cfg.step_imag      <= cfg_data;
        etfp_pkg::REG_MAX_ITER:    cfg.max_iterations <= cfg_data[etfp_pkg::LIMIT_W-1:0];
        etfp_pkg::REG_ALGORITHM:   cfg.algorithm      <= cfg_data[etfp_pkg::ALG_W-1:0];
        etfp_pkg::REG_EXPONENT:    cfg.exponent       <= cfg_data[etfp_pkg::EXPO_W-1:0];
        etfp_pkg::REG_TEST_MODE:   cfg.test_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  etfp_seq #(
    .COORD_BITS   (COORD_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .ITER_BITS    (ITER_BITS),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .start   (start),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .busy    (busy),
    .done    (done),
    .count   (count),
    .op      (op),
    .res     (res)
  );

  etfp_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .res (res)
  );

  assign iteration_count = etfp_pkg::LIMIT_W'(count);

endmodule

// ----- bench/escape_time_fractal_pixel_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for escape_time_fractal_pixel: directed corners, then random pixel words.
// Depends on etfp_pkg and the escape_time_fractal_pixel RTL; a scoreboard class predicts counts.
module escape_time_fractal_pixel_tb;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 28;
  localparam int ITER_BITS    = 20;
  localparam int MAX_EXPONENT = 15;

  localparam logic [etfp_pkg::ALG_W-1:0] ALG_UNKNOWN_A = 2'd2;
  localparam logic [etfp_pkg::ALG_W-1:0] ALG_UNKNOWN_B = 2'd3;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam longint FIX_ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] ACC_TOP    = (66'sd1 <<< 63) - 66'sd1;
  localparam logic signed [65:0] ACC_BOTTOM = -(66'sd1 <<< 63);
  localparam logic signed [65:0] ESCAPE_MAG = 66'sd2 <<< (2 * FRAC_BITS);

  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 97;

  class fractal_scoreboard;
    etfp_pkg::cfg_t regs;
    logic [etfp_pkg::LIMIT_W-1:0] expected_counts[$];
    int errors;
    int checked;
    int at_limit;

    function new();
      regs = '0;
      regs.max_iterations = 20'd256;
      regs.algorithm = etfp_pkg::ALG_SQUARE;
      regs.exponent = 4'd2;
      errors = 0;
      checked = 0;
      at_limit = 0;
    endfunction

    function void write_reg(etfp_pkg::reg_idx_t idx, logic [etfp_pkg::WORD_W-1:0] data);
      case (idx)
        etfp_pkg::REG_ORIGIN_REAL: regs.origin_real = data;
        etfp_pkg::REG_ORIGIN_IMAG: regs.origin_imag = data;
        etfp_pkg::REG_STEP_REAL:   regs.step_real = data;
        etfp_pkg::REG_STEP_IMAG:   regs.step_imag = data;
        etfp_pkg::REG_MAX_ITER:    regs.max_iterations = data[etfp_pkg::LIMIT_W-1:0];
        etfp_pkg::REG_ALGORITHM:   regs.algorithm = data[etfp_pkg::ALG_W-1:0];
        etfp_pkg::REG_EXPONENT:    regs.exponent = data[etfp_pkg::EXPO_W-1:0];
        etfp_pkg::REG_TEST_MODE:   regs.test_mode = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
    endfunction

    // a*b + c*d, saturated to 64 bits, floored to the word's fraction, saturated to 32 bits
    function longint product_sum(longint a, longint b, longint c, longint d);
      logic signed [65:0] acc;
      acc = 66'(a) * 66'(b) + 66'(c) * 66'(d);
      if (acc > ACC_TOP) begin
        acc = ACC_TOP;
      end else if (acc < ACC_BOTTOM) begin
        acc = ACC_BOTTOM;
      end
      return clamp_word(longint'(acc >>> FRAC_BITS));
    endfunction

    function logic [etfp_pkg::LIMIT_W-1:0] escape_count(logic [COORD_BITS-1:0] x,
                                                        logic [COORD_BITS-1:0] y);
      longint cr, ci, zr, zi, wr, wi, nr;
      logic signed [65:0] mag;
      logic [31:0] prod;
      int power;
      int unsigned i, limit;
      if (regs.test_mode) begin
        prod = 32'(x) * 32'(y);
        return {{(etfp_pkg::LIMIT_W-8){1'b0}}, prod[7:0]};
      end
      if (regs.algorithm != etfp_pkg::ALG_SQUARE && regs.algorithm != etfp_pkg::ALG_POWER)
        return '0;
      cr = clamp_word(longint'($signed(regs.origin_real)) +
                      longint'(x) * longint'($signed(regs.step_real)));
      ci = clamp_word(longint'($signed(regs.origin_imag)) +
                      longint'(y) * longint'($signed(regs.step_imag)));
      power = (regs.algorithm == etfp_pkg::ALG_SQUARE) ? 2 : int'(regs.exponent);
      if (power > MAX_EXPONENT) power = MAX_EXPONENT;
      limit = 32'(regs.max_iterations);
      zr = 0;
      zi = 0;
      for (i = 0; i < limit; i++) begin
        wr = FIX_ONE;
        wi = 0;
        repeat (power) begin
          nr = product_sum(wr, zr, -wi, zi);
          wi = product_sum(wr, zi, wi, zr);
          wr = nr;
        end
        zr = clamp_word(wr - cr);
        zi = clamp_word(wi - ci);
        mag = 66'(zr) * 66'(zr) + 66'(zi) * 66'(zi);
        if (mag >= ESCAPE_MAG) break;
      end
      if (limit != 0 && i == limit) at_limit++;
      return i[etfp_pkg::LIMIT_W-1:0];
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
      expected_counts.push_back(escape_count(x, y));
    endfunction

    function void check_count(logic [etfp_pkg::LIMIT_W-1:0] got);
      logic [etfp_pkg::LIMIT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        errors++;
        $error("iteration_count: expected nothing, got %0d", got);
        return;
      end
      want = expected_counts.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $error("iteration_count: expected %0d, got %0d", want, got);
      end
    endfunction

    function int outstanding();
      return expected_counts.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [etfp_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [etfp_pkg::WORD_W-1:0]      cfg_data;
  logic                             start;
  logic                             busy;
  logic [COORD_BITS-1:0]            pixel_x;
  logic [COORD_BITS-1:0]            pixel_y;
  logic                             done;
  logic [etfp_pkg::LIMIT_W-1:0]     iteration_count;

  fractal_scoreboard sb = new();
  etfp_pkg::cfg_t setting;
  int idle_pct;
  int settings_written;

  escape_time_fractal_pixel #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS(FRAC_BITS),
    .ITER_BITS(ITER_BITS),
    .MAX_EXPONENT(MAX_EXPONENT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .done(done),
    .iteration_count(iteration_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_pixel(pixel_x, pixel_y);
    if (!rst && done) sb.check_count(iteration_count);
  end

  // all driving tasks start and end at a falling edge
  task automatic write_reg(etfp_pkg::reg_idx_t idx, logic [etfp_pkg::WORD_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data = $urandom;
    sb.write_reg(idx, data);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0 || busy) @(negedge clk);
  endtask

  // narrow registers get random upper bits, which the block must drop
  task automatic configure(etfp_pkg::cfg_t c);
    wait_drained();
    write_reg(etfp_pkg::REG_ORIGIN_REAL, c.origin_real);
    write_reg(etfp_pkg::REG_ORIGIN_IMAG, c.origin_imag);
    write_reg(etfp_pkg::REG_STEP_REAL, c.step_real);
    write_reg(etfp_pkg::REG_STEP_IMAG, c.step_imag);
    write_reg(etfp_pkg::REG_MAX_ITER, {12'($urandom), c.max_iterations});
    write_reg(etfp_pkg::REG_ALGORITHM, {30'($urandom), c.algorithm});
    write_reg(etfp_pkg::REG_EXPONENT, {28'($urandom), c.exponent});
    write_reg(etfp_pkg::REG_TEST_MODE, {31'($urandom), c.test_mode});
    settings_written++;
  endtask

  task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      pixel_x = COORD_BITS'($urandom);
      pixel_y = COORD_BITS'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    pixel_x = x;
    pixel_y = y;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
    pixel_x = COORD_BITS'($urandom);
    pixel_y = COORD_BITS'($urandom);
  endtask

  initial begin
    int idle_table[4];
    int kind, sz, power, span;
    logic [COORD_BITS-1:0] top;
    idle_table = '{0, 76, 0, 10};
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = etfp_pkg::REG_ORIGIN_REAL;
    cfg_data = '0;
    start = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    idle_pct = 0;
    settings_written = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values: c is zero, so both corners run to the limit of 256
    send_pixel('0, '0);
    send_pixel('1, '1);

    setting = sb.regs;
    setting.test_mode = 1'b1;
    setting.max_iterations = '1;
    configure(setting);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(16'hAAAA, 16'h5555);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'h00FF, 16'h0101);

    setting.test_mode = 1'b0;
    setting.algorithm = ALG_UNKNOWN_A;
    configure(setting);
    send_pixel(16'h1234, 16'h4321);
    setting.algorithm = ALG_UNKNOWN_B;
    configure(setting);
    send_pixel(16'h8000, 16'h0001);

    // saturated c at the corners escapes at once even with the largest limit
    setting.algorithm = etfp_pkg::ALG_SQUARE;
    setting.origin_real = 32'h8000_0000;
    setting.origin_imag = 32'h7FFF_FFFF;
    setting.step_real = 32'h7FFF_FFFF;
    setting.step_imag = 32'h8000_0000;
    configure(setting);
    send_pixel('0, '0);
    send_pixel('0, '1);
    send_pixel('1, '0);
    send_pixel('1, '1);

    setting.origin_real = '0;
    setting.origin_imag = '0;
    setting.step_real = 32'sd4096;
    setting.step_imag = 32'sd4096;
    setting.max_iterations = '0;
    configure(setting);
    send_pixel(16'd100, 16'd100);
    setting.max_iterations = 20'd1;
    configure(setting);
    send_pixel('0, '0);

    setting.algorithm = etfp_pkg::ALG_POWER;
    setting.exponent = 4'd0;
    setting.max_iterations = 20'd20;
    configure(setting);
    send_pixel('0, '0);
    send_pixel('1, '0);
    setting.exponent = 4'd1;
    configure(setting);
    send_pixel('1, '1);
    setting.exponent = 4'd15;
    setting.max_iterations = 20'd6;
    configure(setting);
    send_pixel('0, '0);
    send_pixel(16'd40000, 16'd20000);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = ph % 6;
      sz = (kind == 0 || kind == 1 || kind == 4) ? int'($urandom_range(8, 16)) : 16;
      span = 3 << FRAC_BITS;
      setting.test_mode = 1'b0;
      setting.exponent = 4'($urandom);
      setting.max_iterations = 20'($urandom_range(1, 48));
      setting.origin_real = -(1 << FRAC_BITS) + int'($urandom_range(0, 1 << 27)) - (1 << 26);
      setting.origin_imag = -(3 << (FRAC_BITS - 1)) + int'($urandom_range(0, 1 << 26));
      setting.step_real = span >>> sz;
      setting.step_imag = span >>> sz;
      setting.algorithm = etfp_pkg::ALG_SQUARE;
      case (kind)
        1: begin
          setting.algorithm = etfp_pkg::ALG_POWER;
        end
        2, 5: begin
          setting.origin_real = $signed($urandom) >>> $urandom_range(0, 31);
          setting.origin_imag = $signed($urandom) >>> $urandom_range(0, 31);
          setting.step_real = $signed($urandom) >>> $urandom_range(0, 31);
          setting.step_imag = $signed($urandom) >>> $urandom_range(0, 31);
          if (kind == 5) setting.algorithm = 2'($urandom);
        end
        3: begin
          setting.test_mode = 1'b1;
          setting.algorithm = 2'($urandom);
          setting.max_iterations = 20'($urandom);
        end
        4: begin
          setting.origin_real = 2 << FRAC_BITS;
          setting.origin_imag = 3 << (FRAC_BITS - 1);
          setting.step_real = -(span >>> sz);
          setting.step_imag = -(span >>> sz);
        end
        default: ;
      endcase
      // keep higher powers short: each iteration costs one multiply pass for every power above one
      if (!setting.test_mode && setting.algorithm == etfp_pkg::ALG_POWER) begin
        power = int'(setting.exponent);
        setting.max_iterations = 20'($urandom_range(1, 1000 / (18 + 8 * power)));
      end
      configure(setting);
      idle_pct = idle_table[ph % 4];
      top = COORD_BITS'((1 << sz) - 1);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_pixel(COORD_BITS'($urandom_range(0, top)), COORD_BITS'($urandom_range(0, top)));
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.outstanding() != 0) begin
      sb.errors++;
      $error("iteration_count: %0d words never came back", sb.outstanding());
    end
    $display("%0d pixel words checked over %0d register settings,", sb.checked,
             settings_written);
    $display("%0d of them ran to the iteration limit", sb.at_limit);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/etfp_pkg.sv
hdl/etfp_mac.sv
hdl/etfp_seq.sv
hdl/escape_time_fractal_pixel.sv
bench/escape_time_fractal_pixel_tb.sv
